/* src/usc_pkg.sv */
// Package for the URI component splitter.
// Holds the item types, character constants, escape states and the hex digit decode.
// No dependencies.
package usc_pkg;

	localparam int MAX_COMPONENTS_DEF = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = 1;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_PCT,
		PEND_HELD
	} pend_t;

	typedef struct packed {
		logic [7:0] ch;
		logic has_char;
		logic end_of_uri;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic byte_valid;
		logic [5:0] comp_index;
		logic comp_end;
		logic name_end;
		logic [5:0] comp_count;
		logic run_last;
	} out_t;

	typedef struct packed {
		logic two;
		out_t r0;
		out_t r1;
	} bundle_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = 4'(c[3:0] + 4'd9);
		end
		return v;
	endfunction

endpackage

/* src/usc_front.sv */
// Front end of the URI component splitter: accepts characters, tracks escapes and
// components, and builds the one or two results of each item.
// Depends on usc_pkg.
module usc_front #(
	parameter int MAX_NAME_COMPONENTS = usc_pkg::MAX_COMPONENTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input usc_pkg::in_t in_data,
	input logic q_ready,
	output logic in_ready,
	output logic push,
	output usc_pkg::bundle_t push_data
);

	localparam int CW = $clog2(MAX_NAME_COMPONENTS);
	localparam logic [CW-1:0] LIMIT = CW'(MAX_NAME_COMPONENTS - 1);

	usc_pkg::pend_t pend_q, pend_d;
	logic [7:0] held_q, held_d;
	logic start_q, start_d;
	logic open_q, open_d;
	logic [CW-1:0] cnt_q, cnt_d;

	logic fire;
	logic is_chr, fin, skip, close_req, data, do_close;
	logic [1:0] n;
	usc_pkg::out_t r0, r1, x;
	logic [5:0] idx6;

	function automatic logic [5:0] to6(input logic [CW-1:0] v);
		logic [CW+5:0] w;
		w = {6'd0, v};
		return w[5:0];
	endfunction

	function automatic usc_pkg::out_t mk(input logic [7:0] b, input logic bv, input logic ce,
			input logic [5:0] idx);
		usc_pkg::out_t o;
		o = '0;
		o.out_byte = bv ? b : 8'd0;
		o.byte_valid = bv;
		o.comp_index = idx;
		o.comp_end = ce;
		return o;
	endfunction

	assign in_ready = q_ready;
	assign fire = in_valid && in_ready;

	always_comb begin
		pend_d = pend_q;
		held_d = held_q;
		start_d = start_q;
		open_d = open_q;
		cnt_d = cnt_q;
		n = 2'd0;
		r0 = '0;
		r1 = '0;
		x = '0;
		idx6 = to6(cnt_q);
		is_chr = in_data.has_char && (in_data.ch != usc_pkg::CH_NUL);
		fin = in_data.end_of_uri || (in_data.has_char && (in_data.ch == usc_pkg::CH_NUL));
		skip = 1'b0;
		close_req = 1'b0;
		data = 1'b0;

		if (is_chr) begin
			skip = start_q && (in_data.ch == usc_pkg::CH_SLASH);
			start_d = 1'b0;
			if (!skip && (open_q || (cnt_q < LIMIT))) begin
				open_d = 1'b1;
				if (in_data.ch == usc_pkg::CH_SLASH) begin
					close_req = 1'b1;
				end else begin
					data = 1'b1;
				end
			end
		end

		if (data) begin
			unique case (pend_q)
				usc_pkg::PEND_NONE: begin
					if (in_data.ch == usc_pkg::CH_PERCENT) begin
						pend_d = usc_pkg::PEND_PCT;
					end else begin
						r0 = mk(in_data.ch, 1'b1, 1'b0, idx6);
						n = 2'd1;
					end
				end
				usc_pkg::PEND_PCT: begin
					held_d = in_data.ch;
					pend_d = usc_pkg::PEND_HELD;
				end
				default: begin
					r0 = mk({usc_pkg::hex_value(held_q), usc_pkg::hex_value(in_data.ch)},
						1'b1, 1'b0, idx6);
					n = 2'd1;
					pend_d = usc_pkg::PEND_NONE;
				end
			endcase
		end

		do_close = close_req || (fin && open_d);
		if (do_close) begin
			if (pend_d != usc_pkg::PEND_NONE) begin
				x = mk(usc_pkg::CH_PERCENT, 1'b1, 1'b0, idx6);
				if (n == 2'd0) begin
					r0 = x;
				end else begin
					r1 = x;
				end
				n = n + 2'd1;
			end
			if (pend_d == usc_pkg::PEND_HELD) begin
				x = mk(held_d, 1'b1, 1'b0, idx6);
				if (n == 2'd0) begin
					r0 = x;
				end else begin
					r1 = x;
				end
				n = n + 2'd1;
			end
			if (n == 2'd2) begin
				r1.comp_end = 1'b1;
			end else if (n == 2'd1) begin
				r0.comp_end = 1'b1;
			end else begin
				r0 = mk(8'd0, 1'b0, 1'b1, idx6);
				n = 2'd1;
			end
			cnt_d = cnt_q + CW'(1);
			open_d = 1'b0;
			pend_d = usc_pkg::PEND_NONE;
		end

		if (fin) begin
			if (n == 2'd0) begin
				r0 = mk(8'd0, 1'b0, 1'b0, 6'd0);
				n = 2'd1;
			end
			if (n == 2'd2) begin
				r1.name_end = 1'b1;
				r1.comp_count = to6(cnt_d);
			end else begin
				r0.name_end = 1'b1;
				r0.comp_count = to6(cnt_d);
			end
			pend_d = usc_pkg::PEND_NONE;
			held_d = 8'd0;
			start_d = 1'b1;
			open_d = 1'b0;
			cnt_d = '0;
		end

		r0.run_last = (n == 2'd1);
		r1.run_last = 1'b1;
	end

	assign push = fire && (n != 2'd0);
	assign push_data = '{two: (n == 2'd2), r0: r0, r1: r1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= usc_pkg::PEND_NONE;
			held_q <= 8'd0;
			start_q <= 1'b1;
			open_q <= 1'b0;
			cnt_q <= '0;
		end else if (fire) begin
			pend_q <= pend_d;
			held_q <= held_d;
			start_q <= start_d;
			open_q <= open_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

/* src/usc_queue.sv */
// Short queue of result bundles between the front and back ends of the splitter.
// Depends on usc_pkg.
module usc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input usc_pkg::bundle_t push_data,
	output logic push_ready,
	input logic pop,
	output logic pop_valid,
	output usc_pkg::bundle_t pop_data
);

	localparam int AW = usc_pkg::QUEUE_AW;
	localparam int DEPTH = usc_pkg::QUEUE_DEPTH;

	usc_pkg::bundle_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != (AW + 1)'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data = mem_q[rp_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (AW + 1)'(1);
			end
		end
	end

endmodule

/* src/usc_back.sv */
// Back end of the splitter: unpacks each bundle into one or two results on the
// output register. Depends on usc_pkg.
module usc_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input usc_pkg::bundle_t q_data,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output usc_pkg::out_t out_data
);

	logic valid_q;
	logic sec_q;
	usc_pkg::out_t out_q;
	usc_pkg::out_t r1_q;
	logic adv;

	assign adv = !valid_q || out_ready;
	assign pop = adv && !sec_q && q_valid;
	assign out_valid = valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sec_q) begin
				out_q <= r1_q;
			end else if (q_valid) begin
				out_q <= q_data.r0;
				r1_q <= q_data.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sec_q <= 1'b0;
		end else if (adv) begin
			if (sec_q) begin
				valid_q <= 1'b1;
				sec_q <= 1'b0;
			end else if (q_valid) begin
				valid_q <= 1'b1;
				sec_q <= q_data.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/uri_component_splitter.sv */
// Top level of the URI component splitter: front end, bundle queue and back end.
// Depends on usc_pkg, usc_front, usc_queue and usc_back.
//
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_ready   in_data   (usc_pkg::in_t)
// out       out  out_valid / out_ready out_data  (usc_pkg::out_t)
//
// One character item is accepted per cycle while the queue has room.
// An item's first result is registered in the back end's output register when the back end advances;
// an item with two results holds back the next bundle until its second result is loaded into that register.
// Reset returns the parser to the start of a URI and empties the queue.
// Input and output stall independently; the queue absorbs two bundles.
module uri_component_splitter #(
	parameter int MAX_NAME_COMPONENTS = usc_pkg::MAX_COMPONENTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input usc_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output usc_pkg::out_t out_data
);

	logic push, push_ready, pop, pop_valid;
	usc_pkg::bundle_t push_data, pop_data;

	usc_front #(
		.MAX_NAME_COMPONENTS(MAX_NAME_COMPONENTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_data(in_data),
		.q_ready(push_ready),
		.in_ready(in_ready),
		.push(push),
		.push_data(push_data)
	);

	usc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.push_ready(push_ready),
		.pop(pop),
		.pop_valid(pop_valid),
		.pop_data(pop_data)
	);

	usc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(pop_valid),
		.q_data(pop_data),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	a_name_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.name_end |-> out_data.run_last)
		else $error("name end result is not the last result of its item");

	a_count_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.name_end |-> out_data.comp_count == 6'd0)
		else $error("component count shown before name end");

	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0)
		else $error("byte field not zero on a result without a byte");

	a_result_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.byte_valid || out_data.comp_end || out_data.name_end)
		else $error("result carries no byte and no marker");

endmodule
